>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PIDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PIDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/pidc_pkg.sv
// Constants, types and register indexes for the clamped PID controller.
`default_nettype none

package pidc_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 48;

  localparam int GAIN_W  = 16;
  localparam int TSTEP_W = 16;

  // Shared multiplier: signed gain (or zero-extended time step) times a 33-bit operand.
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Wide operands are split into a 32-bit unsigned low chunk and a signed high chunk.
  localparam int CHUNK_W = 32;
  localparam int EXT_W   = 64;
  localparam int WIDE_W  = EXT_W + GAIN_W;
  localparam int SAT_W   = EXT_W + 2;

  localparam int P_SHIFT = 8;
  localparam int I_SHIFT = 24;
  localparam int D_SHIFT = 8;

  localparam int DERIV_W = 48;
  localparam logic signed [EXT_W-1:0] DERIV_LIM = (64'sd1 <<< (DERIV_W - 1)) - 64'sd1;

  localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd256;

  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KP_GAIN = 3'd0,
    REG_KI_GAIN = 3'd1,
    REG_KD_GAIN = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } reg_idx_t;

  typedef logic signed [MUL_A_W-1:0] mula_t;
  typedef logic signed [MUL_B_W-1:0] mulb_t;
  typedef logic signed [EXT_W-1:0]   ext_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [SAT_W-1:0]   sat_t;

endpackage

`default_nettype wire

>>> rtl/core/pid_controller_clamped.sv
// Clamped fixed-point PID controller with a shared multiplier and a serial divider.
// An accepted input runs through S_DELTA, S_PTERM, S_ILO, S_IHI, S_ICLAMP, S_DIV, S_DSGN, S_DLO,
// S_DHI, S_SUM, S_SAT and S_FIN before out_valid; a clear or a zero time step goes straight to S_FIN.
// A new control step is accepted only back in S_IDLE (in_stall is high otherwise); the radix-2 divider
// retires one quotient bit per cycle over DATA_WIDTH + 17 bits, and S_FIN waits while out_stall holds.
// Reset (synchronous, rst_n low) clears the integral and last error and loads the default gains.
`default_nettype none

`include "assert_macros.svh"

module pid_controller_clamped #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = pidc_pkg::ACC_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      in_op,
  input  logic signed [DATA_WIDTH-1:0]              in_target,
  input  logic signed [DATA_WIDTH-1:0]              in_measured,
  input  logic [pidc_pkg::TSTEP_W-1:0]              in_time_step,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [DATA_WIDTH-1:0]              out_drive,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [(DATA_WIDTH > 16 ? DATA_WIDTH : 16)-1:0] cfg_wdata
);

  localparam int NUM_W = DATA_WIDTH + 1 + pidc_pkg::TSTEP_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam pidc_pkg::sat_t AMAX = (pidc_pkg::sat_t'(1) <<< (ACC_WIDTH - 1))
                                    - pidc_pkg::sat_t'(1);
  localparam pidc_pkg::sat_t AMIN = -AMAX - pidc_pkg::sat_t'(1);
  localparam pidc_pkg::wide_t DMAX = (pidc_pkg::wide_t'(1) <<< (DATA_WIDTH - 1))
                                     - pidc_pkg::wide_t'(1);
  localparam pidc_pkg::wide_t DMIN = -DMAX - pidc_pkg::wide_t'(1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DELTA  = 13'b0000000000010,
    S_PTERM  = 13'b0000000000100,
    S_ILO    = 13'b0000000001000,
    S_IHI    = 13'b0000000010000,
    S_ICLAMP = 13'b0000000100000,
    S_DIV    = 13'b0000001000000,
    S_DSGN   = 13'b0000010000000,
    S_DLO    = 13'b0000100000000,
    S_DHI    = 13'b0001000000000,
    S_SUM    = 13'b0010000000000,
    S_SAT    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [pidc_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic signed [DATA_WIDTH-1:0]       min_r, max_r;

  // Loop state
  logic signed [ACC_WIDTH-1:0]  integ_r, integ_nxt;
  logic signed [DATA_WIDTH:0]   last_err_r, last_err_nxt;

  // Working registers
  logic signed [DATA_WIDTH:0]         err_r, err_nxt;
  logic [pidc_pkg::TSTEP_W-1:0]       dt_r, dt_nxt;
  pidc_pkg::wide_t                    acc_r, acc_nxt;
  pidc_pkg::wide_t                    sum_r, sum_nxt;
  logic [pidc_pkg::TSTEP_W-1:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0]                   quo_r, quo_nxt;
  logic                               neg_r, neg_nxt;
  logic [CNT_W-1:0]                   div_cnt_r, div_cnt_nxt;
  logic signed [pidc_pkg::DERIV_W-1:0] deriv_r, deriv_nxt;
  logic signed [DATA_WIDTH-1:0]       pre_r, pre_nxt;
  logic                               zero_r, zero_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0]       drive_r, drive_nxt;

  // Shared multiplier
  pidc_pkg::mula_t                     mul_a;
  pidc_pkg::mulb_t                     mul_b;
  logic signed [pidc_pkg::MUL_P_W-1:0] mul_p;
  pidc_pkg::wide_t                     mul_ext;
  pidc_pkg::wide_t                     mul_hi;

  pidc_pkg::ext_t integ_ext;
  pidc_pkg::ext_t deriv_ext;

  // Combinational helpers
  pidc_pkg::sat_t               isum_c;
  pidc_pkg::wide_t              ival_c;
  pidc_pkg::wide_t              iclamp_c;
  logic signed [DATA_WIDTH+1:0] diff_c;
  logic signed [DATA_WIDTH+1:0] mag_c;
  logic [pidc_pkg::TSTEP_W:0]   rsh_c;
  logic [pidc_pkg::TSTEP_W:0]   rdif_c;
  logic                         qbit_c;
  pidc_pkg::ext_t               qext_c;
  pidc_pkg::ext_t               qlim_c;
  logic signed [DATA_WIDTH-1:0] cap_c;
  logic signed [DATA_WIDTH-1:0] clamp_c;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign cfg_ready = 1'b1;

  assign integ_ext = pidc_pkg::ext_t'(integ_r);
  assign deriv_ext = pidc_pkg::ext_t'(deriv_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DELTA: begin
        mul_a = pidc_pkg::mula_t'({1'b0, dt_r});
        mul_b = pidc_pkg::mulb_t'(err_r);
      end
      S_PTERM: begin
        mul_a = pidc_pkg::mula_t'(kp_r);
        mul_b = pidc_pkg::mulb_t'(err_r);
      end
      S_ILO: begin
        mul_a = pidc_pkg::mula_t'(ki_r);
        mul_b = {1'b0, integ_ext[pidc_pkg::CHUNK_W-1:0]};
      end
      S_IHI: begin
        mul_a = pidc_pkg::mula_t'(ki_r);
        mul_b = pidc_pkg::mulb_t'($signed(integ_ext[pidc_pkg::EXT_W-1:pidc_pkg::CHUNK_W]));
      end
      S_DLO: begin
        mul_a = pidc_pkg::mula_t'(kd_r);
        mul_b = {1'b0, deriv_ext[pidc_pkg::CHUNK_W-1:0]};
      end
      S_DHI: begin
        mul_a = pidc_pkg::mula_t'(kd_r);
        mul_b = pidc_pkg::mulb_t'($signed(deriv_ext[pidc_pkg::EXT_W-1:pidc_pkg::CHUNK_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_ext = pidc_pkg::wide_t'(mul_p);
  assign mul_hi  = mul_ext <<< pidc_pkg::CHUNK_W;

  // Saturating integral update.
  assign isum_c = pidc_pkg::sat_t'(integ_r) + pidc_pkg::sat_t'(acc_r);

  // Integral term, clamped high limit first so crossed limits resolve as specified.
  assign ival_c = acc_r >>> pidc_pkg::I_SHIFT;
  always_comb begin
    if (ival_c > pidc_pkg::wide_t'(max_r)) begin
      iclamp_c = pidc_pkg::wide_t'(max_r);
    end else if (ival_c < pidc_pkg::wide_t'(min_r)) begin
      iclamp_c = pidc_pkg::wide_t'(min_r);
    end else begin
      iclamp_c = ival_c;
    end
  end

  // Divider set-up and one restoring step.
  assign diff_c = {err_r[DATA_WIDTH], err_r} - {last_err_r[DATA_WIDTH], last_err_r};
  assign mag_c  = diff_c[DATA_WIDTH+1] ? -diff_c : diff_c;
  assign rsh_c  = {rem_r, quo_r[NUM_W-1]};
  assign rdif_c = rsh_c - {1'b0, dt_r};
  assign qbit_c = (rsh_c >= {1'b0, dt_r});

  assign qext_c = pidc_pkg::ext_t'(quo_r);
  assign qlim_c = (qext_c > pidc_pkg::DERIV_LIM) ? pidc_pkg::DERIV_LIM : qext_c;

  // Output limits: min(out_max) first, then max(out_min).
  assign cap_c   = (pre_r > max_r) ? max_r : pre_r;
  assign clamp_c = (cap_c < min_r) ? min_r : cap_c;

  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    last_err_nxt  = last_err_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    div_cnt_nxt   = div_cnt_r;
    deriv_nxt     = deriv_r;
    pre_nxt       = pre_r;
    zero_nxt      = zero_r;
    drive_nxt     = drive_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt = {in_target[DATA_WIDTH-1], in_target}
                    - {in_measured[DATA_WIDTH-1], in_measured};
          dt_nxt  = in_time_step;
          if (in_op) begin
            integ_nxt    = '0;
            last_err_nxt = '0;
            zero_nxt     = 1'b1;
            state_nxt    = S_FIN;
          end else if (in_time_step == '0) begin
            zero_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = S_DELTA;
          end
        end
      end
      S_DELTA: begin
        acc_nxt   = mul_ext;
        state_nxt = S_PTERM;
      end
      S_PTERM: begin
        if (isum_c > AMAX) begin
          integ_nxt = AMAX[ACC_WIDTH-1:0];
        end else if (isum_c < AMIN) begin
          integ_nxt = AMIN[ACC_WIDTH-1:0];
        end else begin
          integ_nxt = isum_c[ACC_WIDTH-1:0];
        end
        acc_nxt   = mul_ext;
        state_nxt = S_ILO;
      end
      S_ILO: begin
        sum_nxt   = acc_r >>> pidc_pkg::P_SHIFT;
        acc_nxt   = mul_ext;
        state_nxt = S_IHI;
      end
      S_IHI: begin
        acc_nxt   = acc_r + mul_hi;
        state_nxt = S_ICLAMP;
      end
      S_ICLAMP: begin
        sum_nxt     = sum_r + iclamp_c;
        rem_nxt     = '0;
        quo_nxt     = {mag_c[DATA_WIDTH:0], {pidc_pkg::TSTEP_W{1'b0}}};
        neg_nxt     = diff_c[DATA_WIDTH+1];
        div_cnt_nxt = CNT_W'(NUM_W);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        rem_nxt     = qbit_c ? rdif_c[pidc_pkg::TSTEP_W-1:0] : rsh_c[pidc_pkg::TSTEP_W-1:0];
        quo_nxt     = {quo_r[NUM_W-2:0], qbit_c};
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if (div_cnt_r == CNT_W'(1)) begin
          state_nxt = S_DSGN;
        end
      end
      S_DSGN: begin
        // Quotient truncates toward zero, so the sign goes on after the magnitude divide.
        deriv_nxt = neg_r ? -$signed(qlim_c[pidc_pkg::DERIV_W-1:0])
                          : $signed(qlim_c[pidc_pkg::DERIV_W-1:0]);
        state_nxt = S_DLO;
      end
      S_DLO: begin
        acc_nxt   = mul_ext;
        state_nxt = S_DHI;
      end
      S_DHI: begin
        acc_nxt   = acc_r + mul_hi;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = sum_r + (acc_r >>> pidc_pkg::D_SHIFT);
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (sum_r > DMAX) begin
          pre_nxt = DMAX[DATA_WIDTH-1:0];
        end else if (sum_r < DMIN) begin
          pre_nxt = DMIN[DATA_WIDTH-1:0];
        end else begin
          pre_nxt = sum_r[DATA_WIDTH-1:0];
        end
        last_err_nxt = err_r;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          drive_nxt     = zero_r ? '0 : clamp_c;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    dt_r      <= dt_nxt;
    acc_r     <= acc_nxt;
    sum_r     <= sum_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    neg_r     <= neg_nxt;
    div_cnt_r <= div_cnt_nxt;
    deriv_r   <= deriv_nxt;
    pre_r     <= pre_nxt;
    zero_r    <= zero_nxt;
    drive_r   <= drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= pidc_pkg::KP_RESET;
      ki_r  <= '0;
      kd_r  <= '0;
      min_r <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      max_r <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        pidc_pkg::REG_KP_GAIN: kp_r  <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KI_GAIN: ki_r  <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KD_GAIN: kd_r  <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_OUT_MIN: min_r <= cfg_wdata[DATA_WIDTH-1:0];
        pidc_pkg::REG_OUT_MAX: max_r <= cfg_wdata[DATA_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  `PIDC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "sequencer not idle after reset")
  `PIDC_ASSERT(a_result_from_fin, $rose(out_valid_r) |-> $past(state_r == S_FIN), "result raised outside the final step")
  `PIDC_ASSERT(a_zero_path, in_valid && !in_stall && (in_op || (in_time_step == '0)) |=> zero_r && (state_r == S_FIN), "clear or zero time step did not take the zero path")
  `PIDC_ASSERT(a_div_count, (state_r == S_DIV) |-> (div_cnt_r != '0), "divider ran past its last quotient bit")
  `PIDC_ASSERT(a_drive_limits, (state_r == S_FIN) && !zero_r && (min_r <= max_r) |-> (clamp_c >= min_r) && (clamp_c <= max_r), "drive outside its limits")

endmodule

`default_nettype wire
